### hw/rtl/wche_pkg.sv
// ----------------------------------------------------------------------------
// wche_pkg
// Shared types and constants for the waveform channel hit extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package wche_pkg;

    localparam int NUM_CHANNELS_DEF = 48;

    localparam int CH_W     = 6;
    localparam int ADC_W    = 16;
    localparam int TDC_W    = 15;
    localparam int TIME_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADC_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HIT    = 1'd1;

    localparam logic [ADC_W-1:0] ADC_THRESHOLD_RST = 16'd1;

    // Fastest count that means "no hit seen"
    localparam logic [TDC_W-1:0] TDC_NONE = 15'h7fff;
    // Borrow bit folded into the trigger time on wrap
    localparam logic [TIME_W-1:0] TIME_BORROW = 16'h8000;

    typedef struct packed {
        logic [ADC_W-1:0] charge_acc;
        logic [TDC_W-1:0] fastest_tdc;
        logic [TDC_W-1:0] previous_fastest_tdc;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        charge_acc:           '0,
        fastest_tdc:          TDC_NONE,
        previous_fastest_tdc: TDC_NONE
    };

endpackage

`default_nettype wire

### hw/rtl/waveform_channel_hit_extractor_core.sv
// ----------------------------------------------------------------------------
// waveform_channel_hit_extractor_core
// Per-channel charge sum and fastest TDC tracking, hit emission on last sample.
// ----------------------------------------------------------------------------
// A result passes through the stage 1 register and then the output register
// before it is driven on m_tdata; a stall on the output can hold it in stage 1.
// Throughput: one sample per cycle while the output is free; a sample that gives
// two results is sent as two beats by the single output register, holding stage 1.
// Channel state sits in a one-write, one-read memory; a per-channel valid flag,
// cleared by reset at once, makes an unwritten entry read as its reset value.
// Reset also restores threshold 1 and second-hit mode off. No clearing pass.
`default_nettype none

module waveform_channel_hit_extractor_core
    import wche_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [5:0] channel, [21:6] adc_sample, [37:22] tdc_word,
    // [53:38] trigger_time, [55:54] zero
    input  wire logic [55:0]           s_tdata,
    input  wire logic                  s_tlast,       // final_sample

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [5:0] hit_channel, [21:6] hit_time, [37:22] charge_sum, [39:38] zero
    output logic [39:0]                m_tdata,
    output logic                       m_tuser,       // is_second
    output logic                       m_tlast        // last
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [ADC_W-1:0] adc_threshold_reg;
    logic             second_hit_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_threshold_reg     <= ADC_THRESHOLD_RST;
            second_hit_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADC_THRESHOLD: adc_threshold_reg <= cfg_data;
                REG_SECOND_HIT:    second_hit_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------------
    logic [CH_W-1:0]   in_channel;
    logic [ADC_W-1:0]  in_adc;
    logic [15:0]       in_tdc_word;
    logic [TIME_W-1:0] in_trigger;
    logic [IDX_W-1:0]  in_idx;
    logic              in_accept;

    assign in_channel  = s_tdata[5:0];
    assign in_adc      = s_tdata[21:6];
    assign in_tdc_word = s_tdata[37:22];
    assign in_trigger  = s_tdata[53:38];
    assign in_idx      = IDX_W'(in_channel);
    assign in_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Stage 1: registered sample plus registered entry read
    // ------------------------------------------------------------------------
    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_channel_reg;
    logic [ADC_W-1:0]  s1_adc_reg;
    logic [15:0]       s1_tdc_word_reg;
    logic              s1_final_reg;
    logic [TIME_W-1:0] s1_trigger_reg;
    logic              s1_in_range_reg;

    entry_t            mem [NUM_CHANNELS];
    logic              entry_vld_reg [NUM_CHANNELS];
    entry_t            rd_data_reg;
    logic              rd_vld_reg;
    entry_t            byp_reg;
    logic              use_byp_reg;

    logic              out_free;
    logic              s1_adv;
    logic [IDX_W-1:0]  s1_idx;

    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s1_idx   = IDX_W'(s1_channel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_channel_reg  <= in_channel;
            s1_adc_reg      <= in_adc;
            s1_tdc_word_reg <= in_tdc_word;
            s1_final_reg    <= s_tlast;
            s1_trigger_reg  <= in_trigger;
            s1_in_range_reg <= (32'(in_channel) < NUM_CHANNELS);
        end
    end

    // ------------------------------------------------------------------------
    // Entry update
    // ------------------------------------------------------------------------
    entry_t            cur;
    entry_t            upd;
    entry_t            wr_entry;
    logic [TDC_W-1:0]  tdc_cnt;
    logic              take_tdc;
    logic              hit;
    logic              two_results;
    logic [TIME_W-1:0] trig_adj;
    logic [TIME_W-1:0] first_time;
    logic              s1_commit;

    always_comb
    begin
        if (use_byp_reg)
            cur = byp_reg;
        else if (rd_vld_reg)
            cur = rd_data_reg;
        else
            cur = ENTRY_RESET;

        upd = cur;
        if (s1_adc_reg > adc_threshold_reg)
            upd.charge_acc = cur.charge_acc + s1_adc_reg;

        tdc_cnt  = s1_tdc_word_reg[TDC_W-1:0];
        take_tdc = s1_tdc_word_reg[15] && (tdc_cnt != '0) && (tdc_cnt < cur.fastest_tdc);
        if (take_tdc)
        begin
            upd.previous_fastest_tdc = cur.fastest_tdc;
            upd.fastest_tdc          = tdc_cnt;
        end

        hit         = s1_in_range_reg && s1_final_reg && (upd.fastest_tdc != TDC_NONE);
        two_results = hit && second_hit_enable_reg;

        // Borrow from bit 15 when the trigger precedes the fastest count
        if (s1_trigger_reg < {1'b0, upd.fastest_tdc})
            trig_adj = s1_trigger_reg | TIME_BORROW;
        else
            trig_adj = s1_trigger_reg;
        first_time = trig_adj - {1'b0, upd.fastest_tdc};

        wr_entry  = s1_final_reg ? ENTRY_RESET : upd;
        s1_commit = s1_adv && s1_in_range_reg;
    end

    // Entry storage: written on a non-final commit, read on accept
    always_ff @(posedge clk)
    begin
        if (s1_commit && !s1_final_reg)
            mem[s1_idx] <= upd;
        if (in_accept)
            rd_data_reg <= mem[in_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                entry_vld_reg[i] <= 1'b0;
            rd_vld_reg  <= 1'b0;
            use_byp_reg <= 1'b0;
        end
        else
        begin
            if (s1_commit)
                entry_vld_reg[s1_idx] <= !s1_final_reg;
            if (in_accept)
            begin
                rd_vld_reg  <= entry_vld_reg[in_idx];
                // Forward the entry being written this cycle to the same channel
                use_byp_reg <= s1_commit && (s1_channel_reg == in_channel);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            byp_reg <= wr_entry;
    end

    // ------------------------------------------------------------------------
    // Output register: one or two beats per hit
    // ------------------------------------------------------------------------
    logic              out_valid_reg;
    logic              out_phase_reg;
    logic              out_two_reg;
    logic [CH_W-1:0]   out_channel_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic [TIME_W-1:0] out_prev_reg;
    logic [ADC_W-1:0]  out_sum_reg;
    logic              out_final_beat;
    logic [TIME_W-1:0] out_hit_time;

    assign out_final_beat = (out_phase_reg == out_two_reg);
    assign out_free       = !out_valid_reg || (m_tready && out_final_beat);
    assign out_hit_time   = out_phase_reg ? out_prev_reg : out_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_phase_reg <= 1'b0;
            out_two_reg   <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= hit;
            out_phase_reg <= 1'b0;
            out_two_reg   <= two_results;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (out_final_beat)
                out_valid_reg <= 1'b0;
            else
                out_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_channel_reg <= s1_channel_reg;
            out_time_reg    <= first_time;
            out_prev_reg    <= {1'b0, upd.previous_fastest_tdc};
            out_sum_reg     <= upd.charge_acc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_hit_time, out_channel_reg};
    assign m_tuser  = out_phase_reg;
    assign m_tlast  = out_final_beat;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_second_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> second_hit_enable_reg)
        else $error("second-hit beat with second-hit mode off");

    a_first_of_two_not_second: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !m_tuser)
        else $error("non-final beat marked as second hit");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser && m_tlast)
        else $error("second-hit beat missing after first beat");

    a_bypass_on_same_channel: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s1_commit && (s1_channel_reg == in_channel) |=> use_byp_reg)
        else $error("same-channel entry not forwarded");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("sample accepted while stage 1 is blocked");

endmodule

`default_nettype wire
